// ----- sv/pearson_correlation_assert.svh -----
// Assertion macros used by the top-level RTL file pearson_correlation.sv.
`ifndef PEARSON_CORRELATION_ASSERT_SVH
`define PEARSON_CORRELATION_ASSERT_SVH

`ifndef SYNTHESIS
`define PC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pearson_correlation: same-cycle check failed");
`define PC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pearson_correlation: next-cycle check failed");
`else
`define PC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/pc_pkg.sv -----
`timescale 1ns / 1ps
package pc_pkg;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_COUNT   = 65536;
    localparam int IN_W        = 16;
    localparam int COEF_W      = 16;
    localparam int PAIR_W      = 17;

    localparam int NW     = $clog2(MAX_COUNT + 1);
    localparam int SX_W   = SAMPLE_BITS + NW;
    localparam int SXX_W  = 2 * SAMPLE_BITS - 1 + NW;
    localparam int SXY_W  = 2 * SAMPLE_BITS - 1 + NW;
    localparam int TW     = ((NW + SXY_W > 2 * SX_W) ? NW + SXY_W : 2 * SX_W) + 1;
    localparam int MW     = TW;
    localparam int PW     = 2 * MW;
    localparam int M_BITS = COEF_W;
    localparam int Q_SHIFT = 2 * M_BITS;
    localparam int SW     = PW + Q_SHIFT + 4;
    localparam int SCNT_W = $clog2(M_BITS);
    localparam int MCNT_W = $clog2(MW + 1);

    typedef enum logic [2:0] {
        SEL_NXX, SEL_XX, SEL_NYY, SEL_YY, SEL_NXY, SEL_XY, SEL_AB, SEL_CC
    } t_mul_sel;

    typedef struct packed {
        logic     acc_en;
        logic     mul_start;
        logic     mul_store;
        t_mul_sel sel;
        logic     search_init;
        logic     search_step;
        logic     out_fire;
    } t_pc_cmd;

    typedef struct packed {
        logic mul_done;
        logic degenerate;
    } t_pc_stat;
endpackage

// ----- sv/pearson_correlation.sv -----
`timescale 1ns / 1ps
// Pearson correlation of a stream of signed pairs. Pulse i_start with a pair
// while o_busy is low; each pair is summed as it is taken, so pairs may
// arrive on every cycle while o_busy is low. The pair marked i_last_pair
// starts the final computation: six serial multiplies for the three cross
// terms, two more for the variance product and the squared covariance when
// both variances are positive, then a 16-step bitwise root search. A single
// shift-add multiplier, one bit per cycle over 67 bits, sets the length, and
// o_busy stays high until the result is out. The result shows on the o_ ports
// with o_valid, which is high for exactly one cycle; the receiver cannot
// stall it and must take it then. All sums clear with it.
`include "pearson_correlation_assert.svh"
module pearson_correlation import pc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [IN_W-1:0]   i_sample_x,
    input  logic [IN_W-1:0]   i_sample_y,
    input  logic              i_last_pair,
    output logic              o_valid,
    output logic [COEF_W-1:0] o_coefficient,
    output logic              o_degenerate,
    output logic              o_overflow,
    output logic [PAIR_W-1:0] o_pair_count
);
    t_pc_cmd  w_cmd;
    t_pc_stat w_stat;

    pc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_last_pair (i_last_pair),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (o_busy)
    );

    pc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_coefficient (o_coefficient),
        .o_degenerate  (o_degenerate),
        .o_overflow    (o_overflow),
        .o_pair_count  (o_pair_count)
    );

    `PC_ASSERT_SAME(a_valid_idle, i_clk, i_rst_n, o_valid, !o_busy)
    `PC_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)
    `PC_ASSERT_SAME(a_deg_zero, i_clk, i_rst_n, o_valid && o_degenerate, o_coefficient == '0)
    `PC_ASSERT_NEXT(a_pair_stays_idle, i_clk, i_rst_n, i_start && !o_busy && !i_last_pair, !o_busy)
endmodule

// ----- sv/pc_mul.sv -----
`timescale 1ns / 1ps
module pc_mul import pc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_a,
    input  logic [MW-1:0] i_b,
    output logic          o_done,
    output logic [PW-1:0] o_prod
);
    logic              r_busy;
    logic              r_done;
    logic [MCNT_W-1:0] r_cnt;
    logic [PW-1:0]     r_prod;
    logic [MW-1:0]     r_mcand;
    logic [MW:0]       w_sum;

    // add the multiplicand into the upper half when the low multiplier bit is set
    assign w_sum = {1'b0, r_prod[PW-1:MW]} + (r_prod[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MCNT_W'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod  <= {{MW{1'b0}}, i_b};
            r_mcand <= i_a;
        end else if (r_busy) begin
            r_prod <= {w_sum, r_prod[MW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule

// ----- sv/pc_ctrl.sv -----
`timescale 1ns / 1ps
module pc_ctrl import pc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_last_pair,
    input  t_pc_stat i_stat,
    output t_pc_cmd  o_cmd,
    output logic     o_busy
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL_GO, S_MUL_RUN, S_CHECK, S_SRCH_INIT, S_SEARCH, S_DONE
    } t_state;

    t_state            r_state;
    t_mul_sel          r_sel;
    logic [SCNT_W-1:0] r_scnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_NXX;
            r_scnt  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start && i_last_pair) begin
                        r_sel   <= SEL_NXX;
                        r_state <= S_MUL_GO;
                    end
                end
                S_MUL_GO: r_state <= S_MUL_RUN;
                S_MUL_RUN: begin
                    if (i_stat.mul_done) begin
                        if (r_sel == SEL_XY) begin
                            r_state <= S_CHECK;
                        end else if (r_sel == SEL_CC) begin
                            r_state <= S_SRCH_INIT;
                        end else begin
                            r_sel   <= t_mul_sel'(r_sel + 3'd1);
                            r_state <= S_MUL_GO;
                        end
                    end
                end
                S_CHECK: begin
                    // skip the root search when a variance term is not positive
                    if (i_stat.degenerate) begin
                        r_state <= S_DONE;
                    end else begin
                        r_sel   <= SEL_AB;
                        r_state <= S_MUL_GO;
                    end
                end
                S_SRCH_INIT: begin
                    r_scnt  <= SCNT_W'(M_BITS - 1);
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (r_scnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_scnt <= r_scnt - 1'b1;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd     = '0;
        o_cmd.sel = r_sel;
        case (r_state)
            S_IDLE:      o_cmd.acc_en      = i_start;
            S_MUL_GO:    o_cmd.mul_start   = 1'b1;
            S_MUL_RUN:   o_cmd.mul_store   = i_stat.mul_done;
            S_SRCH_INIT: o_cmd.search_init = 1'b1;
            S_SEARCH:    o_cmd.search_step = 1'b1;
            S_DONE:      o_cmd.out_fire    = 1'b1;
            default:     o_cmd.acc_en      = 1'b0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ----- sv/pc_dp.sv -----
`timescale 1ns / 1ps
module pc_dp import pc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pc_cmd           i_cmd,
    input  logic [IN_W-1:0]   i_sample_x,
    input  logic [IN_W-1:0]   i_sample_y,
    output t_pc_stat          o_stat,
    output logic              o_valid,
    output logic [COEF_W-1:0] o_coefficient,
    output logic              o_degenerate,
    output logic              o_overflow,
    output logic [PAIR_W-1:0] o_pair_count
);
    localparam logic [M_BITS-1:0] LO_MAX  = M_BITS'(1) << (M_BITS - 1);
    localparam logic [M_BITS-1:0] POS_MAX = LO_MAX - 1'b1;

    logic signed [SAMPLE_BITS-1:0]   w_x, w_y;
    logic signed [2*SAMPLE_BITS-1:0] w_xx, w_yy, w_xy;

    logic [NW-1:0]           r_n;
    logic                    r_ovf;
    logic signed [SX_W-1:0]  r_sx, r_sy;
    logic signed [SXX_W-1:0] r_sxx, r_syy;
    logic signed [SXY_W-1:0] r_sxy;

    logic signed [TW-1:0] r_a, r_b, r_c;
    logic [PW-1:0]        r_p;
    logic signed [SW-1:0] r_q;
    logic                 r_mul_neg;

    logic signed [SW-1:0] r_t2, r_u, r_ps;
    logic [M_BITS-1:0]    r_m, r_bit;

    logic                 r_valid, r_deg_o, r_ovf_o;
    logic [COEF_W-1:0]    r_coef;
    logic [PAIR_W-1:0]    r_cnt_o;

    logic signed [MW-1:0] w_sx_e, w_sy_e, w_sxx_e, w_syy_e, w_sxy_e, w_c_e;
    logic [MW-1:0]        w_sx_m, w_sy_m, w_sxx_m, w_syy_m, w_sxy_m, w_c_m, w_n_e;
    logic [MW-1:0]        w_mul_a, w_mul_b;
    logic                 w_mul_neg;
    logic                 w_mul_done;
    logic [PW-1:0]        w_prod;
    logic signed [TW-1:0] w_sprod;
    logic signed [SW-1:0] w_p_e, w_cand;
    logic                 w_fit, w_deg;
    logic [M_BITS-1:0]    w_lo;
    logic [COEF_W-1:0]    w_coef;

    assign w_x  = i_sample_x[SAMPLE_BITS-1:0];
    assign w_y  = i_sample_y[SAMPLE_BITS-1:0];
    assign w_xx = w_x * w_x;
    assign w_yy = w_y * w_y;
    assign w_xy = w_x * w_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_ovf <= 1'b0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
        end else if (i_cmd.out_fire) begin
            r_n   <= '0;
            r_ovf <= 1'b0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
        end else if (i_cmd.acc_en) begin
            // drop pairs past the count limit, flag them
            if (r_n < NW'(MAX_COUNT)) begin
                r_n   <= r_n + 1'b1;
                r_sx  <= r_sx + SX_W'(w_x);
                r_sy  <= r_sy + SX_W'(w_y);
                r_sxx <= r_sxx + SXX_W'(w_xx);
                r_syy <= r_syy + SXX_W'(w_yy);
                r_sxy <= r_sxy + SXY_W'(w_xy);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign w_n_e   = MW'(r_n);
    assign w_sx_e  = MW'(r_sx);
    assign w_sy_e  = MW'(r_sy);
    assign w_sxx_e = MW'(r_sxx);
    assign w_syy_e = MW'(r_syy);
    assign w_sxy_e = MW'(r_sxy);
    assign w_c_e   = MW'(r_c);
    assign w_sx_m  = w_sx_e  < 0 ? -w_sx_e  : w_sx_e;
    assign w_sy_m  = w_sy_e  < 0 ? -w_sy_e  : w_sy_e;
    assign w_sxx_m = w_sxx_e < 0 ? -w_sxx_e : w_sxx_e;
    assign w_syy_m = w_syy_e < 0 ? -w_syy_e : w_syy_e;
    assign w_sxy_m = w_sxy_e < 0 ? -w_sxy_e : w_sxy_e;
    assign w_c_m   = w_c_e   < 0 ? -w_c_e   : w_c_e;

    always_comb begin
        w_mul_a   = w_n_e;
        w_mul_b   = w_sxx_m;
        w_mul_neg = 1'b0;
        case (i_cmd.sel)
            SEL_NXX: begin
                w_mul_a = w_n_e;
                w_mul_b = w_sxx_m;
            end
            SEL_XX: begin
                w_mul_a = w_sx_m;
                w_mul_b = w_sx_m;
            end
            SEL_NYY: begin
                w_mul_a = w_n_e;
                w_mul_b = w_syy_m;
            end
            SEL_YY: begin
                w_mul_a = w_sy_m;
                w_mul_b = w_sy_m;
            end
            SEL_NXY: begin
                w_mul_a   = w_n_e;
                w_mul_b   = w_sxy_m;
                w_mul_neg = r_sxy < 0;
            end
            SEL_XY: begin
                w_mul_a   = w_sx_m;
                w_mul_b   = w_sy_m;
                w_mul_neg = (r_sx < 0) ^ (r_sy < 0);
            end
            SEL_AB: begin
                w_mul_a = MW'(r_a);
                w_mul_b = MW'(r_b);
            end
            SEL_CC: begin
                w_mul_a = w_c_m;
                w_mul_b = w_c_m;
            end
            default: w_mul_neg = 1'b0;
        endcase
    end

    pc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_sprod = r_mul_neg ? -$signed(w_prod[TW-1:0]) : $signed(w_prod[TW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mul_neg <= w_mul_neg;
        end
        if (i_cmd.mul_store) begin
            case (i_cmd.sel)
                SEL_NXX: r_a <= w_sprod;
                SEL_XX:  r_a <= r_a - w_sprod;
                SEL_NYY: r_b <= w_sprod;
                SEL_YY:  r_b <= r_b - w_sprod;
                SEL_NXY: r_c <= w_sprod;
                SEL_XY:  r_c <= r_c - w_sprod;
                SEL_AB:  r_p <= w_prod;
                SEL_CC:  r_q <= SW'(w_prod) <<< Q_SHIFT;
                default: r_p <= w_prod;
            endcase
        end
    end

    // Bitwise search for the largest m with (2m-1)^2 * A*B <= 2^32 * C^2.
    // r_t2 holds t^2*P, r_u holds t*P scaled to the bit under test, r_ps P scaled.
    assign w_p_e  = SW'(r_p);
    assign w_cand = r_t2 + r_u + r_ps;
    assign w_fit  = (w_cand <= r_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.search_init) begin
            r_t2  <= w_p_e;
            r_u   <= -(w_p_e <<< (M_BITS + 1));
            r_ps  <= w_p_e <<< (2 * M_BITS);
            r_m   <= '0;
            r_bit <= LO_MAX;
        end else if (i_cmd.search_step) begin
            if (w_fit) begin
                r_t2 <= w_cand;
                r_u  <= (r_u + (r_ps <<< 1)) >>> 1;
                r_m  <= r_m | r_bit;
            end else begin
                r_u <= r_u >>> 1;
            end
            r_ps  <= r_ps >>> 2;
            r_bit <= r_bit >> 1;
        end
    end

    assign w_deg = (r_a <= 0) || (r_b <= 0);
    assign w_lo  = (r_m > LO_MAX) ? LO_MAX : r_m;

    always_comb begin
        if (w_deg) begin
            w_coef = '0;
        end else if (r_c < 0) begin
            w_coef = COEF_W'(-w_lo);
        end else begin
            w_coef = COEF_W'((w_lo > POS_MAX) ? POS_MAX : w_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_fire) begin
            r_coef  <= w_coef;
            r_deg_o <= w_deg;
            r_ovf_o <= r_ovf;
            r_cnt_o <= PAIR_W'(r_n);
        end
    end

    assign o_stat.mul_done   = w_mul_done;
    assign o_stat.degenerate = w_deg;
    assign o_valid       = r_valid;
    assign o_coefficient = r_coef;
    assign o_degenerate  = r_deg_o;
    assign o_overflow    = r_ovf_o;
    assign o_pair_count  = r_cnt_o;
endmodule
